// ----- src/jfdd_pkg.sv -----
// ----------------------------------------------------------------------------
// jfdd_pkg
// Shared types and constants for the joystick frame to differential drive
// mixer: payload structs, register codes and fixed frame constants.
// ----------------------------------------------------------------------------
package jfdd_pkg;

  // frame layout
  localparam int unsigned FRAME_BYTES = 6;
  localparam int unsigned POS_W       = 3;
  localparam logic [7:0]  SYNC_BYTE   = 8'hAA;

  // mixing constants
  localparam int unsigned JOY_W      = 12;
  localparam int unsigned MAG_W      = 11;
  localparam int unsigned DUTY_W     = 16;
  localparam int unsigned PROD_W     = MAG_W + DUTY_W;
  localparam int signed   CENTRE     = 2048;
  localparam int signed   FULL_SCALE = 2047;

  // input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // motor direction codes
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_X_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_X_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_Y_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_Y_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_MAX     = 3'd4;

  // register reset values
  localparam logic [JOY_W-1:0]  DEAD_X_LOW_RST  = 12'd1970;
  localparam logic [JOY_W-1:0]  DEAD_X_HIGH_RST = 12'd2010;
  localparam logic [JOY_W-1:0]  DEAD_Y_LOW_RST  = 12'd2050;
  localparam logic [JOY_W-1:0]  DEAD_Y_HIGH_RST = 12'd2090;
  localparam logic [DUTY_W-1:0] PWM_MAX_RST     = 16'd1999;

  typedef logic [JOY_W-1:0]  joy_t;
  typedef logic [MAG_W-1:0]  mag_t;
  typedef logic [DUTY_W-1:0] duty_t;
  typedef logic [1:0]        dir_t;
  typedef logic [PROD_W-1:0] prod_t;

  typedef struct packed {
    joy_t  dead_x_low;
    joy_t  dead_x_high;
    joy_t  dead_y_low;
    joy_t  dead_y_high;
    duty_t pwm_max;
  } cfg_t;

  // checked frame, unpacked
  typedef struct packed {
    joy_t x;
    joy_t y;
  } frame_pl_t;

  // mixed motor magnitudes and directions
  typedef struct packed {
    joy_t x;
    joy_t y;
    dir_t l_dir;
    dir_t r_dir;
    mag_t l_mag;
    mag_t r_mag;
  } mix_pl_t;

endpackage

// ----- src/jfdd_if.sv -----
// ----------------------------------------------------------------------------
// jfdd channel interfaces
// Valid/ready channels for received bytes, motor results and register writes.
// ----------------------------------------------------------------------------
interface jfdd_in_if import jfdd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface jfdd_out_if import jfdd_pkg::*; ();
  logic  valid;
  logic  ready;
  joy_t  joy_x;
  joy_t  joy_y;
  dir_t  left_dir;
  dir_t  right_dir;
  duty_t left_duty;
  duty_t right_duty;

  modport source (output valid, output joy_x, output joy_y, output left_dir,
                  output right_dir, output left_duty, output right_duty,
                  input ready);
  modport sink   (input valid, input joy_x, input joy_y, input left_dir,
                  input right_dir, input left_duty, input right_duty,
                  output ready);
endinterface

interface jfdd_cfg_if import jfdd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/jfdd_frame.sv -----
// ----------------------------------------------------------------------------
// jfdd_frame
// Six-byte frame store with write position; on end of burst checks sync byte
// and XOR checksum and registers the unpacked stick values.
// ----------------------------------------------------------------------------
module jfdd_frame import jfdd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  jfdd_in_if.sink   in_ch,
  output logic      dn_valid,
  input  logic      dn_ready,
  output frame_pl_t dn_pl
);

  logic [7:0]       store_r [FRAME_BYTES];
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic             v_r;
  frame_pl_t        pl_r;
  logic             acc;
  logic             is_end;
  logic             has_room;
  logic             frame_ok;

  // stage accepts when empty or draining
  assign in_ch.ready = !v_r || dn_ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign is_end      = (in_ch.op == OP_END);
  assign has_room    = (pos_r < POS_W'(FRAME_BYTES));

  // frame check against store as it stands
  assign frame_ok = (store_r[0] == SYNC_BYTE) &&
                    ((store_r[1] ^ store_r[2] ^ store_r[3] ^ store_r[4]) == store_r[5]);

  // byte store, later bytes of a long burst dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        store_r[i] <= 8'h00;
      end
    end else if (acc && !is_end && has_room) begin
      store_r[pos_r] <= in_ch.rx_byte;
    end
  end

  // write position
  always_comb begin
    pos_nxt = pos_r;
    priority if (acc && is_end) begin
      pos_nxt = '0;
    end else if (acc && has_room) begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // checked frame register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ch.ready) begin
      v_r <= acc && is_end && frame_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      pl_r.x <= {store_r[1][3:0], store_r[2]};
      pl_r.y <= {store_r[3][3:0], store_r[4]};
    end
  end

  assign dn_valid = v_r;
  assign dn_pl    = pl_r;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(FRAME_BYTES))
    else $error("frame write position out of range");

  a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_end) |=> (pos_r == '0))
    else $error("write position not cleared at end of burst");

  a_bad_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_end && !frame_ok) |=> !v_r)
    else $error("invalid frame passed the check");
`endif

endmodule

// ----- src/jfdd_mix.sv -----
// ----------------------------------------------------------------------------
// jfdd_mix
// Deadband test and arcade mixing of the stick values into clamped left and
// right magnitudes with directions.
// ----------------------------------------------------------------------------
module jfdd_mix import jfdd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      up_valid,
  output logic      up_ready,
  input  frame_pl_t up_pl,
  output logic      dn_valid,
  input  logic      dn_ready,
  output mix_pl_t   dn_pl
);

  localparam logic signed [13:0] CTR  = 14'(CENTRE);
  localparam logic signed [13:0] FS_P = 14'(FULL_SCALE);
  localparam logic signed [13:0] FS_N = -14'(FULL_SCALE);

  logic              v_r;
  mix_pl_t           pl_r;
  mix_pl_t           pl_nxt;
  logic signed [13:0] drive;
  logic signed [13:0] steer;
  logic signed [13:0] l_clamp;
  logic signed [13:0] r_clamp;
  logic               in_dead;

  function automatic logic signed [13:0] clamp_fs(input logic signed [13:0] v);
    logic signed [13:0] res;
    res = v;
    if (v > FS_P) begin
      res = FS_P;
    end else if (v < FS_N) begin
      res = FS_N;
    end
    return res;
  endfunction

  function automatic mag_t abs_mag(input logic signed [13:0] v);
    logic signed [13:0] a;
    a = (v < 0) ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  assign up_ready = !v_r || dn_ready;

  // signed offsets around the centre and clamped sums
  assign drive   = $signed({2'b00, up_pl.y}) - CTR;
  assign steer   = $signed({2'b00, up_pl.x}) - CTR;
  assign l_clamp = clamp_fs(drive + steer);
  assign r_clamp = clamp_fs(drive - steer);

  assign in_dead = (up_pl.x > cfg.dead_x_low) && (up_pl.x < cfg.dead_x_high) &&
                   (up_pl.y > cfg.dead_y_low) && (up_pl.y < cfg.dead_y_high);

  // deadband forces stop with zero magnitude
  always_comb begin
    pl_nxt.x = up_pl.x;
    pl_nxt.y = up_pl.y;
    if (in_dead) begin
      pl_nxt.l_dir = DIR_STOP;
      pl_nxt.r_dir = DIR_STOP;
      pl_nxt.l_mag = '0;
      pl_nxt.r_mag = '0;
    end else begin
      pl_nxt.l_dir = (l_clamp < 0) ? DIR_REV : DIR_FWD;
      pl_nxt.r_dir = (r_clamp < 0) ? DIR_REV : DIR_FWD;
      pl_nxt.l_mag = abs_mag(l_clamp);
      pl_nxt.r_mag = abs_mag(r_clamp);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      pl_r <= pl_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_pl    = pl_r;

endmodule

// ----- src/jfdd_duty.sv -----
// ----------------------------------------------------------------------------
// jfdd_duty
// Duty scaling |v| * pwm_max / 2047 for both motors: product stage, quotient
// estimate stage and corrected result register driving the output channel.
// ----------------------------------------------------------------------------
module jfdd_duty import jfdd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  duty_t    pwm_max,
  input  logic     up_valid,
  output logic     up_ready,
  input  mix_pl_t  up_pl,
  jfdd_out_if.source out_ch
);

  localparam int unsigned Q_W      = DUTY_W + 1;
  localparam int unsigned REM_W    = 13;
  localparam int unsigned WIDE_W   = PROD_W + 1;
  localparam int unsigned REM_LIM  = 3 * FULL_SCALE;
  localparam int unsigned DIV_SH   = 11;

  typedef struct packed {
    joy_t  x;
    joy_t  y;
    dir_t  l_dir;
    dir_t  r_dir;
    prod_t l_prod;
    prod_t r_prod;
  } prod_pl_t;

  typedef struct packed {
    joy_t             x;
    joy_t             y;
    dir_t             l_dir;
    dir_t             r_dir;
    logic [Q_W-1:0]   l_q;
    logic [Q_W-1:0]   r_q;
    logic [REM_W-1:0] l_rem;
    logic [REM_W-1:0] r_rem;
  } est_pl_t;

  logic     a_v_r;
  logic     b_v_r;
  logic     c_v_r;
  logic     a_adv;
  logic     b_adv;
  logic     c_adv;
  prod_pl_t a_r;
  est_pl_t  b_r;
  est_pl_t  b_nxt;
  duty_t    l_duty_nxt;
  duty_t    r_duty_nxt;
  joy_t     c_x_r;
  joy_t     c_y_r;
  dir_t     c_l_dir_r;
  dir_t     c_r_dir_r;
  duty_t    c_l_duty_r;
  duty_t    c_r_duty_r;

  // quotient estimate for divide by 2^11 - 1, low by at most two
  function automatic logic [Q_W-1:0] q_est(input prod_t p);
    return Q_W'(p >> DIV_SH) + Q_W'(p >> (2 * DIV_SH));
  endfunction

  function automatic logic [REM_W-1:0] rem_of(input prod_t p, input logic [Q_W-1:0] q);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(p) - (WIDE_W'(q) << DIV_SH) + WIDE_W'(q);
    return w[REM_W-1:0];
  endfunction

  function automatic duty_t q_fix(input logic [Q_W-1:0] q, input logic [REM_W-1:0] r);
    logic [Q_W-1:0] res;
    priority if (r >= REM_W'(2 * FULL_SCALE)) begin
      res = q + Q_W'(2);
    end else if (r >= REM_W'(FULL_SCALE)) begin
      res = q + Q_W'(1);
    end else begin
      res = q;
    end
    return res[DUTY_W-1:0];
  endfunction

  // stage advance, each stage moves when the next is empty or draining
  assign c_adv    = !c_v_r || out_ch.ready;
  assign b_adv    = !b_v_r || c_adv;
  assign a_adv    = !a_v_r || b_adv;
  assign up_ready = a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (a_adv) a_v_r <= up_valid;
      if (b_adv) b_v_r <= a_v_r;
      if (c_adv) c_v_r <= b_v_r;
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (a_adv) begin
      a_r.x      <= up_pl.x;
      a_r.y      <= up_pl.y;
      a_r.l_dir  <= up_pl.l_dir;
      a_r.r_dir  <= up_pl.r_dir;
      a_r.l_prod <= PROD_W'(up_pl.l_mag) * PROD_W'(pwm_max);
      a_r.r_prod <= PROD_W'(up_pl.r_mag) * PROD_W'(pwm_max);
    end
  end

  // quotient estimate and remainder
  always_comb begin
    b_nxt.x     = a_r.x;
    b_nxt.y     = a_r.y;
    b_nxt.l_dir = a_r.l_dir;
    b_nxt.r_dir = a_r.r_dir;
    b_nxt.l_q   = q_est(a_r.l_prod);
    b_nxt.r_q   = q_est(a_r.r_prod);
    b_nxt.l_rem = rem_of(a_r.l_prod, b_nxt.l_q);
    b_nxt.r_rem = rem_of(a_r.r_prod, b_nxt.r_q);
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      b_r <= b_nxt;
    end
  end

  // corrected quotient into the result register
  assign l_duty_nxt = q_fix(b_r.l_q, b_r.l_rem);
  assign r_duty_nxt = q_fix(b_r.r_q, b_r.r_rem);

  always_ff @(posedge clk) begin
    if (c_adv) begin
      c_x_r      <= b_r.x;
      c_y_r      <= b_r.y;
      c_l_dir_r  <= b_r.l_dir;
      c_r_dir_r  <= b_r.r_dir;
      c_l_duty_r <= l_duty_nxt;
      c_r_duty_r <= r_duty_nxt;
    end
  end

  assign out_ch.valid      = c_v_r;
  assign out_ch.joy_x      = c_x_r;
  assign out_ch.joy_y      = c_y_r;
  assign out_ch.left_dir   = c_l_dir_r;
  assign out_ch.right_dir  = c_r_dir_r;
  assign out_ch.left_duty  = c_l_duty_r;
  assign out_ch.right_duty = c_r_duty_r;

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    b_v_r |-> ((b_r.l_rem < REM_W'(REM_LIM)) && (b_r.r_rem < REM_W'(REM_LIM))))
    else $error("quotient estimate outside correction range");

  a_duty_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.left_duty <= pwm_max) && (out_ch.right_duty <= pwm_max)))
    else $error("duty above pwm_max");

  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.left_dir == DIR_STOP)) |->
      ((out_ch.right_dir == DIR_STOP) && (out_ch.left_duty == '0) &&
       (out_ch.right_duty == '0)))
    else $error("stopped motors with nonzero duty");
`endif

endmodule

// ----- src/joystick_frame_to_differential_drive.sv -----
// ----------------------------------------------------------------------------
// joystick_frame_to_differential_drive
// Joystick frame receiver and arcade-style differential drive mixer.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries received bytes (op = byte) and end-of-burst marks (op = end).
//   Bytes fill a six-byte frame from slot 0; extra bytes in a burst are dropped.
//   An end mark checks the frame (sync byte, XOR checksum) and, when it passes,
//   sends one transfer on out_ch with stick values, motor directions and duties.
//   cfg_ch writes the deadband limits and pwm_max; cfg_ch.ready is always high
//   and writes to unused indexes are dropped. Write registers only while idle.
// Timing:
//   in_ch takes one transfer per cycle while the stages are not stalled. A result
//   reaches out_ch through the five register stages after its end-of-burst
//   transfer (frame check, mix, multiply, quotient estimate, corrected result).
// Reset:
//   rst_n clears the frame store, the write position, all stage valids and
//   loads the register defaults.
// Stall:
//   when out_ch.ready is low, results hold and the stages fill up; in_ch.ready
//   drops only once every stage holds an item.
// ----------------------------------------------------------------------------
module joystick_frame_to_differential_drive import jfdd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  jfdd_in_if.sink    in_ch,
  jfdd_out_if.source out_ch,
  jfdd_cfg_if.sink   cfg_ch
);

  cfg_t      cfg_r;
  logic      fr_valid;
  logic      fr_ready;
  frame_pl_t fr_pl;
  logic      mx_valid;
  logic      mx_ready;
  mix_pl_t   mx_pl;

  // register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dead_x_low  <= DEAD_X_LOW_RST;
      cfg_r.dead_x_high <= DEAD_X_HIGH_RST;
      cfg_r.dead_y_low  <= DEAD_Y_LOW_RST;
      cfg_r.dead_y_high <= DEAD_Y_HIGH_RST;
      cfg_r.pwm_max     <= PWM_MAX_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_DEAD_X_LOW:  cfg_r.dead_x_low  <= cfg_ch.data[JOY_W-1:0];
        REG_DEAD_X_HIGH: cfg_r.dead_x_high <= cfg_ch.data[JOY_W-1:0];
        REG_DEAD_Y_LOW:  cfg_r.dead_y_low  <= cfg_ch.data[JOY_W-1:0];
        REG_DEAD_Y_HIGH: cfg_r.dead_y_high <= cfg_ch.data[JOY_W-1:0];
        REG_PWM_MAX:     cfg_r.pwm_max     <= cfg_ch.data[DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // frame store and check
  jfdd_frame u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .dn_valid (fr_valid),
    .dn_ready (fr_ready),
    .dn_pl    (fr_pl)
  );

  // deadband and mixing
  jfdd_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (fr_valid),
    .up_ready (fr_ready),
    .up_pl    (fr_pl),
    .dn_valid (mx_valid),
    .dn_ready (mx_ready),
    .dn_pl    (mx_pl)
  );

  // duty scaling and result register
  jfdd_duty u_duty (
    .clk      (clk),
    .rst_n    (rst_n),
    .pwm_max  (cfg_r.pwm_max),
    .up_valid (mx_valid),
    .up_ready (mx_ready),
    .up_pl    (mx_pl),
    .out_ch   (out_ch)
  );

endmodule
